// ----- src/slset_pkg.sv -----
// Shared types, codes and elaboration-time helpers for the sorted label set.
// No dependencies; every other file in src refers to this package by scoped name.
`timescale 1ns / 1ps

package slset_pkg;

  localparam int ACTION_W = 2;
  localparam int LABEL_W  = 32;
  localparam int COUNT_W  = 7;

  // The presence tree folds this many bits per registered level (as a shift).
  localparam int FAN_SH = 3;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

  // Per-cycle command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp;  // capture the compare flags against the request label
    logic ins;  // shift right from the insert point and drop the label in
    logic rem;  // shift left over the removed entry
  } cell_op_t;

  // Number of bits left after k levels of folding n bits.
  function automatic int tree_width(input int n, input int k);
    int w;
    w = n;
    for (int i = 0; i < k; i++) begin
      w = (w + (1 << FAN_SH) - 1) >> FAN_SH;
    end
    return w;
  endfunction

  // Number of registered levels needed to fold n bits down to one.
  function automatic int tree_levels(input int n);
    int w;
    int l;
    w = n;
    l = 0;
    while (w > 1) begin
      w = (w + (1 << FAN_SH) - 1) >> FAN_SH;
      l = l + 1;
    end
    return l;
  endfunction

endpackage

// ----- src/slset_cell.sv -----
// One storage cell of the sorted label chain: holds a label and its compare flags.
// Depends on slset_pkg for the command struct and field widths.
`timescale 1ns / 1ps

module slset_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic                         clk,
  input  slset_pkg::cell_op_t          op,
  input  logic [CNT_W-1:0]             count,
  input  logic [slset_pkg::LABEL_W-1:0] label,
  input  logic                         prev_take,
  input  logic [slset_pkg::LABEL_W-1:0] prev_data,
  input  logic [slset_pkg::LABEL_W-1:0] next_data,
  output logic [slset_pkg::LABEL_W-1:0] data,
  output logic                         take,
  output logic                         hit
);

  logic occ;
  logic gtr;
  logic ge;

  // The cell is at or past the insert point when it is empty or holds a larger label.
  assign take = !occ || gtr;
  // During a removal every occupied cell from the matching one upward pulls from the right.
  assign ge   = hit || (occ && gtr);

  always_ff @(posedge clk) begin
    if (op.cmp) begin
      occ <= (CNT_W'(IDX) < count);
      hit <= (CNT_W'(IDX) < count) && (data == label);
      gtr <= (data > label);
    end
    if (op.ins && take) begin
      data <= prev_take ? prev_data : label;
    end else if (op.rem && ge) begin
      data <= next_data;
    end
  end

endmodule

// ----- src/slset_or_tree.sv -----
// Registered OR reduction that folds the per-cell hit flags into one presence bit.
// Depends on slset_pkg for the level and width helpers.
`timescale 1ns / 1ps

module slset_or_tree #(
  parameter int N = 64
) (
  input  logic         clk,
  input  logic [N-1:0] bits_in,
  output logic         any
);

  localparam int LEVELS = slset_pkg::tree_levels(N);
  localparam int FAN    = 1 << slset_pkg::FAN_SH;

  logic [N-1:0] lvl [1:LEVELS];

  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    localparam int IW = slset_pkg::tree_width(N, k);
    localparam int OW = slset_pkg::tree_width(N, k + 1);
    logic [N-1:0] src;
    if (k == 0) begin : g_first
      assign src = bits_in;
    end else begin : g_inner
      assign src = lvl[k];
    end
    for (genvar j = 0; j < N; j++) begin : g_bit
      if (j < OW) begin : g_used
        localparam int LO = j * FAN;
        localparam int HI = (LO + FAN - 1 < IW) ? LO + FAN - 1 : IW - 1;
        always_ff @(posedge clk) begin
          lvl[k+1][j] <= |src[HI:LO];
        end
      end else begin : g_pad
        always_ff @(posedge clk) begin
          lvl[k+1][j] <= 1'b0;
        end
      end
    end
  end

  assign any = lvl[LEVELS][0];

endmodule

// ----- src/sorted_label_set_top.sv -----
// Top level of the sorted label set: request sequencer, cell chain and presence tree.
// Depends on slset_pkg, slset_cell and slset_or_tree.
`timescale 1ns / 1ps

//  channel   direction  handshake              payload
//  request   in         req_valid / req_stall  action, label
//  response  out        rsp_valid / rsp_stall  found, changed, full_reject, count
//
// Each request runs from acceptance through the match, reduce and apply states back to
// idle before the next acceptance. In the reduce state the per-cell match flags pass
// through the registered presence OR tree, whose depth LEVELS is the ceil of log8 of
// SET_CAPACITY. Reset is synchronous and empties the set by clearing the count; cell
// contents are not cleared and are never read beyond the count. A stalled response
// holds the finished request in its last step, and a new request is taken while an
// earlier response still waits.

module sorted_label_set_top #(
  parameter int SET_CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [slset_pkg::ACTION_W-1:0] action,
  input  logic [slset_pkg::LABEL_W-1:0]  label,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          found,
  output logic                          changed,
  output logic                          full_reject,
  output logic [slset_pkg::COUNT_W-1:0]  count
);

  localparam int CNT_W  = $clog2(SET_CAPACITY + 1);
  localparam int LEVELS = slset_pkg::tree_levels(SET_CAPACITY);
  localparam int RCW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_REDUCE,
    ST_APPLY
  } state_t;

  state_t                          state;
  logic [RCW-1:0]                  red_cnt;
  logic [CNT_W-1:0]                label_count;
  logic [slset_pkg::ACTION_W-1:0]  req_action;
  logic [slset_pkg::LABEL_W-1:0]   req_label;

  slset_pkg::cell_op_t             op;
  logic                            present;
  logic                            is_full;
  logic                            fire;
  logic                            ins_do;
  logic                            rem_do;
  logic [CNT_W-1:0]                label_count_next;
  logic [CNT_W+slset_pkg::COUNT_W-1:0] count_ext;

  logic [slset_pkg::LABEL_W-1:0]   cdata [SET_CAPACITY];
  logic [SET_CAPACITY-1:0]         ctake;
  logic [SET_CAPACITY-1:0]         chit;

  // A new request is only taken while the sequencer is idle.
  assign req_stall = (state != ST_IDLE);

  assign is_full = (label_count == CNT_W'(SET_CAPACITY));
  // The final step completes once the response register is free or being emptied.
  assign fire    = (state == ST_APPLY) && (!rsp_valid || !rsp_stall);
  assign ins_do  = fire && (req_action == slset_pkg::ACT_INSERT) && !present && !is_full;
  assign rem_do  = fire && (req_action == slset_pkg::ACT_REMOVE) && present;

  always_comb begin
    op.cmp = (state == ST_MATCH);
    op.ins = ins_do;
    op.rem = rem_do;
    label_count_next = label_count;
    if (ins_do) begin
      label_count_next = label_count + CNT_W'(1);
    end else if (rem_do) begin
      label_count_next = label_count - CNT_W'(1);
    end
  end

  // The count port carries only the low bits when the capacity is wide.
  assign count_ext = {{slset_pkg::COUNT_W{1'b0}}, label_count_next};

  // The chain: each cell sees its left neighbor for inserts and its right for removals.
  for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
    logic                          p_take;
    logic [slset_pkg::LABEL_W-1:0] p_data;
    logic [slset_pkg::LABEL_W-1:0] n_data;
    if (i == 0) begin : g_head
      assign p_take = 1'b0;
      assign p_data = req_label;
    end else begin : g_body
      assign p_take = ctake[i-1];
      assign p_data = cdata[i-1];
    end
    if (i == SET_CAPACITY - 1) begin : g_tail
      assign n_data = req_label;
    end else begin : g_link
      assign n_data = cdata[i+1];
    end

    slset_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .op        (op),
      .count     (label_count),
      .label     (req_label),
      .prev_take (p_take),
      .prev_data (p_data),
      .next_data (n_data),
      .data      (cdata[i]),
      .take      (ctake[i]),
      .hit       (chit[i])
    );
  end

  slset_or_tree #(
    .N (SET_CAPACITY)
  ) u_tree (
    .clk     (clk),
    .bits_in (chit),
    .any     (present)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      red_cnt     <= '0;
      label_count <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      // A response taken in the same cycle as a new one is loaded stays valid.
      if (rsp_valid && !rsp_stall && !fire) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            req_action <= action;
            req_label  <= label;
            state      <= ST_MATCH;
          end
        end
        ST_MATCH: begin
          red_cnt <= RCW'(LEVELS - 1);
          state   <= ST_REDUCE;
        end
        ST_REDUCE: begin
          if (red_cnt == '0) begin
            state <= ST_APPLY;
          end else begin
            red_cnt <= red_cnt - RCW'(1);
          end
        end
        ST_APPLY: begin
          if (fire) begin
            rsp_valid   <= 1'b1;
            found       <= present;
            changed     <= ins_do || rem_do;
            full_reject <= (req_action == slset_pkg::ACT_INSERT) && !present && is_full;
            count       <= count_ext[slset_pkg::COUNT_W-1:0];
            label_count <= label_count_next;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A response only appears at the end of the final step of a request.
  a_rsp_from_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == ST_APPLY))
    else $error("response raised outside the final step");

  // The held count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    label_count <= CNT_W'(SET_CAPACITY))
    else $error("label count above capacity");

  // A refused insert neither found the label nor changed the set.
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && full_reject) |-> (!found && !changed))
    else $error("full reject combined with found or changed");

  // A successful removal drops the count by exactly one.
  a_remove_count: assert property (@(posedge clk) disable iff (rst)
    rem_do |=> (label_count == $past(label_count) - CNT_W'(1)))
    else $error("removal did not reduce the count by one");

endmodule
